// ===== design/dimap_pkg.sv =====
package dimap_pkg;

  // Widths fixed by the request and result formats
  localparam int ADDR_W     = 44;
  localparam int RADIX_W    = 17;
  localparam int COORD_W    = 16;
  localparam int NUM_DIGITS = 5;
  localparam int NUM_COORDS = 6;
  localparam int CNT_W      = 11;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  // Defaults for the top-level parameters
  localparam int ROW_COUNT_DEF    = 65536;
  localparam int ADDRESS_BITS_DEF = 44;

  // Field codes held in the order register
  localparam logic [2:0] CODE_CHANNEL   = 3'd0;
  localparam logic [2:0] CODE_DIE       = 3'd1;
  localparam logic [2:0] CODE_BANKGROUP = 3'd2;
  localparam logic [2:0] CODE_BANK      = 3'd3;
  localparam logic [2:0] CODE_ROW       = 3'd4;
  localparam logic [2:0] CODE_COLUMN    = 3'd5;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_ORDER     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIE_COUNT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BANKGROUP_COUNT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BANK_COUNT      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BURSTS_PER_ROW  = 3'd5;

  // Reset values
  localparam logic [14:0] RST_FIELD_ORDER     = 15'd18088;
  localparam logic [6:0]  RST_CHANNEL_COUNT   = 7'd1;
  localparam logic [4:0]  RST_DIE_COUNT       = 5'd1;
  localparam logic [4:0]  RST_BANKGROUP_COUNT = 5'd4;
  localparam logic [4:0]  RST_BANK_COUNT      = 5'd4;
  localparam logic [10:0] RST_BURSTS_PER_ROW  = 11'd32;

  // Operations
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_LOAD, SEQ_RUN} seq_state_t;

  typedef struct packed {
    logic        operation;
    logic [43:0] flat_address;
    logic [5:0]  channel_in;
    logic [3:0]  die_in;
    logic [3:0]  bankgroup_in;
    logic [3:0]  bank_in;
    logic [15:0] row_in;
    logic [9:0]  column_in;
  } map_req_t;

  typedef struct packed {
    logic [43:0] address_out;
    logic [5:0]  channel_out;
    logic [3:0]  die_out;
    logic [3:0]  bankgroup_out;
    logic [3:0]  bank_out;
    logic [15:0] row_out;
    logic [9:0]  column_out;
  } map_res_t;

  // Derived mapping set-up shared by the datapaths
  typedef struct packed {
    logic [NUM_DIGITS-1:0][2:0]         code;
    logic [NUM_DIGITS-1:0][RADIX_W-1:0] radix;
    logic [NUM_DIGITS-1:0][ADDR_W-1:0]  scale;
    logic [4:0]                         nbg;
    logic                               die_present;
    logic                               busy;
  } map_cfg_t;

  typedef logic [NUM_COORDS-1:0][COORD_W-1:0] coord_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // Write one digit into its coordinate slot; unknown codes are dropped
  function automatic coord_t put_coord(input coord_t c, input logic [2:0] code,
                                       input logic [COORD_W-1:0] v);
    coord_t r;
    r = c;
    for (int i = 0; i < NUM_COORDS; i++) begin
      if (code == 3'(i)) r[i] = v;
    end
    return r;
  endfunction

endpackage

// ===== design/dimap_div_stage.sv =====
module dimap_div_stage import dimap_pkg::*; #(
  parameter int QW = 44,
  parameter int SI = 0
) (
  input  logic [QW-1:0]      q_in,
  input  logic [RADIX_W-1:0] rem_in,
  input  logic [RADIX_W-1:0] divisor,
  output logic [QW-1:0]      q_out,
  output logic [RADIX_W-1:0] rem_out
);

  // Up to eight restoring long-division steps, quotient bits replace dividend bits
  always_comb begin
    logic [QW-1:0]      q;
    logic [RADIX_W-1:0] r;
    logic [RADIX_W:0]   t;
    int                 idx;
    q = q_in;
    r = rem_in;
    t = '0;
    for (int k = 0; k < 8; k++) begin
      idx = QW - 1 - SI * 8 - k;
      if (idx >= 0) begin
        t = {r, q[idx]};
        if (t >= {1'b0, divisor}) begin
          t      = t - {1'b0, divisor};
          q[idx] = 1'b1;
        end else begin
          q[idx] = 1'b0;
        end
        r = t[RADIX_W-1:0];
      end
    end
    q_out   = q;
    rem_out = r;
  end

endmodule

// ===== design/dimap_cfg.sv =====
module dimap_cfg import dimap_pkg::*; #(
  parameter int ROW_COUNT = ROW_COUNT_DEF,
  parameter int AW        = ADDRESS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output map_cfg_t               cfg
);

  logic [14:0] field_order;
  logic [6:0]  channel_count;
  logic [4:0]  die_count;
  logic [4:0]  bankgroup_count;
  logic [4:0]  bank_count;
  logic [10:0] bursts_per_row;

  logic [NUM_DIGITS-1:0][2:0]         codes;
  logic [CNT_W-1:0]                   ch_c, die_c, bg_c, bank_c, col_c;
  logic                               die_here;
  logic [9:0]                         bg_wide;
  logic [NUM_DIGITS-1:0][RADIX_W-1:0] radix_next;
  logic [NUM_DIGITS-1:0][RADIX_W-1:0] radix_r;
  logic [4:0]                         nbg_r;
  logic                               die_present_r;
  logic [NUM_DIGITS-1:0][ADDR_W-1:0]  scale_r;

  seq_state_t   state, state_next;
  logic [AW-1:0] acc, acc_next, mcand;
  logic [4:0]    bitc;
  logic [2:0]    digit;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      field_order     <= RST_FIELD_ORDER;
      channel_count   <= RST_CHANNEL_COUNT;
      die_count       <= RST_DIE_COUNT;
      bankgroup_count <= RST_BANKGROUP_COUNT;
      bank_count      <= RST_BANK_COUNT;
      bursts_per_row  <= RST_BURSTS_PER_ROW;
    end else if (wr) begin
      case (wr_index)
        REG_FIELD_ORDER:     field_order     <= wr_data[14:0];
        REG_CHANNEL_COUNT:   channel_count   <= wr_data[6:0];
        REG_DIE_COUNT:       die_count       <= wr_data[4:0];
        REG_BANKGROUP_COUNT: bankgroup_count <= wr_data[4:0];
        REG_BANK_COUNT:      bank_count      <= wr_data[4:0];
        REG_BURSTS_PER_ROW:  bursts_per_row  <= wr_data[10:0];
        default: ;
      endcase
    end
  end

  // Clamped counts and per-digit radix
  always_comb begin
    codes    = field_order;
    die_here = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (codes[i] == CODE_DIE) die_here = 1'b1;
    end
    ch_c   = clamp_count(CNT_W'(channel_count), CNT_W'(64));
    die_c  = clamp_count(CNT_W'(die_count), CNT_W'(16));
    bg_c   = clamp_count(CNT_W'(bankgroup_count), CNT_W'(16));
    bank_c = clamp_count(CNT_W'(bank_count), CNT_W'(16));
    col_c  = clamp_count(bursts_per_row, CNT_W'(1024));
    bg_wide = die_here ? 10'(bg_c) : ({5'b0, die_c[4:0]} * {5'b0, bg_c[4:0]});
    for (int i = 0; i < NUM_DIGITS; i++) begin
      case (codes[i])
        CODE_CHANNEL:   radix_next[i] = RADIX_W'(ch_c);
        CODE_DIE:       radix_next[i] = RADIX_W'(die_c);
        CODE_BANKGROUP: radix_next[i] = RADIX_W'(bg_wide);
        CODE_BANK:      radix_next[i] = RADIX_W'(bank_c);
        CODE_ROW:       radix_next[i] = RADIX_W'(ROW_COUNT);
        CODE_COLUMN:    radix_next[i] = RADIX_W'(col_c);
        default:        radix_next[i] = RADIX_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    radix_r       <= radix_next;
    nbg_r         <= bg_c[4:0];
    die_present_r <= die_here;
  end

  // Scale sequencer: bit-serial products of the radices below each digit
  always_ff @(posedge clk) begin
    if (rst) state <= SEQ_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    acc_next = acc + (radix_r[digit][bitc] ? mcand : '0);
    case (state)
      SEQ_IDLE: state_next = SEQ_IDLE;
      SEQ_LOAD: state_next = SEQ_RUN;
      SEQ_RUN: begin
        if (bitc == 5'(RADIX_W - 1) && digit == 3'(NUM_DIGITS - 2)) state_next = SEQ_IDLE;
        else state_next = SEQ_RUN;
      end
      default: state_next = SEQ_IDLE;
    endcase
    if (wr) state_next = SEQ_LOAD;
  end

  always_ff @(posedge clk) begin
    case (state)
      SEQ_LOAD: begin
        acc        <= '0;
        mcand      <= AW'(1);
        bitc       <= '0;
        digit      <= '0;
        scale_r[0] <= ADDR_W'(1);
      end
      SEQ_RUN: begin
        if (bitc == 5'(RADIX_W - 1)) begin
          scale_r[digit + 3'd1] <= ADDR_W'(acc_next);
          acc   <= '0;
          mcand <= acc_next;
          bitc  <= '0;
          digit <= digit + 3'd1;
        end else begin
          acc   <= acc_next;
          mcand <= mcand << 1;
          bitc  <= bitc + 5'd1;
        end
      end
      default: ;
    endcase
  end

  assign cfg.code        = codes;
  assign cfg.radix       = radix_r;
  assign cfg.scale       = scale_r;
  assign cfg.nbg         = nbg_r;
  assign cfg.die_present = die_present_r;
  assign cfg.busy        = (state != SEQ_IDLE);

endmodule

// ===== design/dimap_decode.sv =====
module dimap_decode import dimap_pkg::*; #(
  parameter int AW = ADDRESS_BITS_DEF
) (
  input  logic          clk,
  input  map_cfg_t      cfg,
  input  logic [AW-1:0] addr,
  output map_res_t      res
);

  localparam int NS = (AW + 7) / 8;
  localparam int T  = NUM_DIGITS * NS;

  logic [AW-1:0]      q_s   [T];
  logic [RADIX_W-1:0] rem_s [T];
  coord_t             crd_s [T];

  // Chain of long-division stages, NS stages per digit
  for (genvar t = 0; t < T; t++) begin : g_stage
    localparam int D = t / NS;
    localparam int S = t % NS;
    logic [AW-1:0]      q_i, q_o;
    logic [RADIX_W-1:0] rem_i, rem_o;
    coord_t             crd_i;

    if (t == 0) begin : g_first
      assign q_i   = addr;
      assign rem_i = '0;
      assign crd_i = '0;
    end else if (S == 0) begin : g_digit
      assign q_i   = q_s[t-1];
      assign rem_i = '0;
      assign crd_i = put_coord(crd_s[t-1], cfg.code[D-1], rem_s[t-1][COORD_W-1:0]);
    end else begin : g_cont
      assign q_i   = q_s[t-1];
      assign rem_i = rem_s[t-1];
      assign crd_i = crd_s[t-1];
    end

    dimap_div_stage #(.QW(AW), .SI(S)) u_div (
      .q_in    (q_i),
      .rem_in  (rem_i),
      .divisor (cfg.radix[D]),
      .q_out   (q_o),
      .rem_out (rem_o)
    );

    always_ff @(posedge clk) begin
      q_s[t]   <= q_o;
      rem_s[t] <= rem_o;
      crd_s[t] <= crd_i;
    end
  end

  // Last digit, then die / bank-group split of the bank-group digit
  coord_t             crd_f;
  logic [7:0]         split_q;
  logic [RADIX_W-1:0] split_r;

  assign crd_f = put_coord(crd_s[T-1], cfg.code[NUM_DIGITS-1], rem_s[T-1][COORD_W-1:0]);

  dimap_div_stage #(.QW(8), .SI(0)) u_split (
    .q_in    (crd_f[CODE_BANKGROUP][7:0]),
    .rem_in  ('0),
    .divisor (RADIX_W'(cfg.nbg)),
    .q_out   (split_q),
    .rem_out (split_r)
  );

  always_ff @(posedge clk) begin
    res.address_out   <= '0;
    res.channel_out   <= crd_f[CODE_CHANNEL][5:0];
    res.die_out       <= cfg.die_present ? crd_f[CODE_DIE][3:0] : split_q[3:0];
    res.bankgroup_out <= split_r[3:0];
    res.bank_out      <= crd_f[CODE_BANK][3:0];
    res.row_out       <= crd_f[CODE_ROW][15:0];
    res.column_out    <= crd_f[CODE_COLUMN][9:0];
  end

endmodule

// ===== design/dimap_encode.sv =====
module dimap_encode import dimap_pkg::*; #(
  parameter int AW = ADDRESS_BITS_DEF
) (
  input  logic              clk,
  input  map_cfg_t          cfg,
  input  map_req_t          req,
  output logic [ADDR_W-1:0] addr
);

  localparam int NS   = (AW + 7) / 8;
  localparam int T    = NUM_DIGITS * NS;
  localparam int HI_W = ADDR_W - 32;
  localparam int DLY  = T - 7;
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((45'(1) << AW) - 45'(1));

  logic [9:0]                          bg_val;
  logic [NUM_DIGITS-1:0][COORD_W-1:0]  v_next;
  logic [NUM_DIGITS-1:0][COORD_W-1:0]  v_r, q1;
  logic [NUM_DIGITS-1:0][RADIX_W-1:0]  r1, r2;
  logic [NUM_DIGITS-1:0][47:0]         lo;
  logic [NUM_DIGITS-1:0][HI_W-1:0]     hi;
  logic [NUM_DIGITS-1:0][ADDR_W-1:0]   term;
  logic [ADDR_W-1:0]                   p0, p1, p2, sa, sb, sum;
  logic [ADDR_W-1:0]                   dly [DLY];

  // Coordinate for each digit
  always_comb begin
    bg_val = ({6'b0, req.die_in} * {5'b0, cfg.nbg}) + 10'(req.bankgroup_in);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      case (cfg.code[d])
        CODE_CHANNEL:   v_next[d] = COORD_W'(req.channel_in);
        CODE_DIE:       v_next[d] = COORD_W'(req.die_in);
        CODE_BANKGROUP: v_next[d] = COORD_W'(bg_val);
        CODE_BANK:      v_next[d] = COORD_W'(req.bank_in);
        CODE_ROW:       v_next[d] = req.row_in;
        CODE_COLUMN:    v_next[d] = COORD_W'(req.column_in);
        default:        v_next[d] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) v_r <= v_next;

  // Coordinate modulo radix, two stages of eight bits
  for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_mod
    logic [COORD_W-1:0] q1_o;
    logic [RADIX_W-1:0] r1_o, r2_o;

    dimap_div_stage #(.QW(COORD_W), .SI(0)) u_div0 (
      .q_in (v_r[d]), .rem_in ('0), .divisor (cfg.radix[d]),
      .q_out (q1_o), .rem_out (r1_o)
    );
    dimap_div_stage #(.QW(COORD_W), .SI(1)) u_div1 (
      .q_in (q1[d]), .rem_in (r1[d]), .divisor (cfg.radix[d]),
      .q_out (), .rem_out (r2_o)
    );

    always_ff @(posedge clk) begin
      q1[d] <= q1_o;
      r1[d] <= r1_o;
      r2[d] <= r2_o;
      // scale times digit, split at bit 32
      lo[d]   <= {16'b0, cfg.scale[d][31:0]} * {32'b0, r2[d][COORD_W-1:0]};
      hi[d]   <= cfg.scale[d][ADDR_W-1:32] * r2[d][HI_W-1:0];
      term[d] <= lo[d][ADDR_W-1:0] + {hi[d], 32'b0};
    end
  end

  // Adder tree and alignment delay
  always_ff @(posedge clk) begin
    p0  <= term[0] + term[1];
    p1  <= term[2] + term[3];
    p2  <= term[4];
    sa  <= p0 + p1;
    sb  <= p2;
    sum <= (sa + sb) & ADDR_MASK;
    dly[0] <= sum;
    for (int i = 1; i < DLY; i++) dly[i] <= dly[i-1];
  end

  assign addr = dly[DLY-1];

endmodule

// ===== design/dram_address_interleave_mapper.sv =====
// DRAM address interleave mapper. Decodes a flat burst address into channel,
// die, bank group, bank, row and column, or encodes those coordinates back
// into an address, under a configurable digit order and field sizes. One
// request may be started in every cycle while busy is low; its result appears
// on result for a single cycle, registered and flagged by done. Both
// datapaths are aligned to the decode chain: five mixed-radix digit
// divisions, each a run of eight-bit restoring-division stages. done cannot
// be held off, so the receiver must take every result as it comes. After
// reset and after every configuration write, busy stays high while a
// bit-serial multiplier rebuilds the per-digit scale factors used by encode.
// Write configuration only with no requests in flight.
module dram_address_interleave_mapper import dimap_pkg::*; #(
  parameter int ROW_COUNT    = ROW_COUNT_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  map_req_t               req,
  output logic                   done,
  output map_res_t               result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int NS = (AW + 7) / 8;
  localparam int T  = NUM_DIGITS * NS;

  map_cfg_t          cfg;
  map_res_t          dec_res, enc_res;
  logic [ADDR_W-1:0] enc_addr;
  logic              accept;
  logic [T:0]        vld;
  logic [T:0]        op_d;

  assign cfg_ready = 1'b1;
  assign busy      = rst | cfg.busy;
  assign accept    = start & ~busy;

  dimap_cfg #(.ROW_COUNT(ROW_COUNT), .AW(AW)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr       (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dimap_decode #(.AW(AW)) u_decode (
    .clk  (clk),
    .cfg  (cfg),
    .addr (req.flat_address[AW-1:0]),
    .res  (dec_res)
  );

  dimap_encode #(.AW(AW)) u_encode (
    .clk  (clk),
    .cfg  (cfg),
    .req  (req),
    .addr (enc_addr)
  );

  // Request tracking alongside the datapaths
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[T-1:0], accept};
      done <= vld[T];
    end
  end

  always_comb begin
    enc_res             = '0;
    enc_res.address_out = enc_addr;
  end

  always_ff @(posedge clk) begin
    op_d   <= {op_d[T-1:0], req.operation};
    result <= (op_d[T] == OP_ENCODE) ? enc_res : dec_res;
  end

endmodule

// ===== design/dimap_checker.sv =====
module dimap_checker import dimap_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_valid,
  input logic cfg_ready
);

  localparam int AW  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int LAT = NUM_DIGITS * ((AW + 7) / 8) + 2;

  // every started request gives exactly one result at fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("started request gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  // scale rebuild after a register write
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("not busy after configuration write");

  a_reset_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

endmodule

bind dram_address_interleave_mapper dimap_checker #(.ADDRESS_BITS(ADDRESS_BITS)) u_chk (.*);
